// ===== rtl/cursor_doubly_linked_list_top_assert.svh =====
// Assertion macros used by the list top module.
`ifndef CURSOR_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH
`define CURSOR_DOUBLY_LINKED_LIST_TOP_ASSERT_SVH

// Implication checked every clock edge outside reset.
`define CDL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define CDL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cdl_pkg.sv =====
// ----------------------------------------------------------------------------
// cdl_pkg
// Shared types and constants for the cursor linked list.
// ----------------------------------------------------------------------------
package cdl_pkg;
  localparam int CAPACITY_DEF    = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int DATA_W          = 32;
  localparam int CMD_W           = 3;
  localparam int STATUS_W        = 2;
  localparam int COUNT_W         = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 3'd0,
    CMD_DELETE = 3'd1,
    CMD_NEXT   = 3'd2,
    CMD_PREV   = 3'd3,
    CMD_READ   = 3'd4,
    CMD_WRITE  = 3'd5,
    CMD_FIRST  = 3'd6,
    CMD_CLEAR  = 3'd7
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_END   = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD1,
    S_RD2,
    S_WR,
    S_WR2,
    S_RV,
    S_OUT
  } state_t;
endpackage

// ===== rtl/cdl_if.sv =====
// ----------------------------------------------------------------------------
// cdl_cmd_if / cdl_rsp_if
// Valid/ready channels carrying list requests and results.
// ----------------------------------------------------------------------------
interface cdl_cmd_if;
  logic                      valid;
  logic                      ready;
  logic [cdl_pkg::CMD_W-1:0] command;
  logic [cdl_pkg::DATA_W-1:0] value;
  modport source (output valid, command, value, input ready);
  modport sink (input valid, command, value, output ready);
endinterface

interface cdl_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [cdl_pkg::STATUS_W-1:0] status;
  logic [cdl_pkg::DATA_W-1:0]   read_value;
  logic [cdl_pkg::COUNT_W-1:0]  count;
  modport source (output valid, status, read_value, count, input ready);
  modport sink (input valid, status, read_value, count, output ready);
endinterface

// ===== rtl/cdl_pool.sv =====
// ----------------------------------------------------------------------------
// cdl_pool
// Node pool: value, next-link and prev-link memories, one write port each
// and one registered read port each, all sharing a read address.
// ----------------------------------------------------------------------------
module cdl_pool #(
  parameter int CAPACITY    = cdl_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = cdl_pkg::VALUE_WIDTH_DEF,
  parameter int AW          = $clog2(CAPACITY),
  parameter int LW          = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic [AW-1:0]          raddr,
  output logic [VALUE_WIDTH-1:0] rval,
  output logic [LW-1:0]          rnext,
  output logic [LW-1:0]          rprev,
  input  logic                   vwe,
  input  logic [AW-1:0]          vaddr,
  input  logic [VALUE_WIDTH-1:0] vdata,
  input  logic                   nwe,
  input  logic [AW-1:0]          naddr,
  input  logic [LW-1:0]          ndata,
  input  logic                   pwe,
  input  logic [AW-1:0]          paddr,
  input  logic [LW-1:0]          pdata
);
  logic [VALUE_WIDTH-1:0] vmem [CAPACITY];
  logic [LW-1:0]          nmem [CAPACITY];
  logic [LW-1:0]          pmem [CAPACITY];

  always_ff @(posedge clk) begin
    if (vwe) vmem[vaddr] <= vdata;
    if (nwe) nmem[naddr] <= ndata;
    if (pwe) pmem[paddr] <= pdata;
    rval  <= vmem[raddr];
    rnext <= nmem[raddr];
    rprev <= pmem[raddr];
  end
endmodule

// ===== rtl/cursor_doubly_linked_list_top.sv =====
// Sequence: the result is registered in OUT, after RV, for read, write, first,
// clear, a full pool and any other request on an empty list, which go from RD1
// to RV; step next and step previous add RD2; insert into an empty list and
// delete of the head add RD2 and WR; other inserts and deletes, which write
// links in WR and WR2, add all three. Throughput: one request at a time; a held
// result stalls only the next request's final cycle. Reset clears head, tail,
// cursor, free list and counts; pool memories are not cleared.
// ----------------------------------------------------------------------------
// cursor_doubly_linked_list_top
// Doubly linked list with cursor in a fixed node pool, with a free list.
// ----------------------------------------------------------------------------
module cursor_doubly_linked_list_top #(
  parameter int CAPACITY    = cdl_pkg::CAPACITY_DEF,
  parameter int VALUE_WIDTH = cdl_pkg::VALUE_WIDTH_DEF
) (
  input logic clk,
  input logic rst,
  cdl_cmd_if.sink   req,
  cdl_rsp_if.source rsp
);
  import cdl_pkg::*;
  `include "cursor_doubly_linked_list_top_assert.svh"

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  state_t state, state_next;

  // List registers.
  logic [LW-1:0] head, tail, cursor, free_head, fresh, count;
  logic [LW-1:0] head_next, tail_next, cursor_next, free_head_next, fresh_next, count_next;

  // The accepted request, and node indexes gathered while it runs.
  cmd_t                   cmd;
  logic [VALUE_WIDTH-1:0] val;
  logic [LW-1:0]          nn, nn_next;   // new node for insert
  logic [LW-1:0]          lp, lp_next;   // latched prev of cursor
  logic [LW-1:0]          ls, ls_next;   // latched next of cursor
  logic [STATUS_W-1:0]    st, st_next;

  // Result register.
  logic                   ovalid;
  logic                   load_out;
  logic [STATUS_W-1:0]    ostatus;
  logic [VALUE_WIDTH-1:0] oval;
  logic [COUNT_W-1:0]     ocount;

  // Pool ports.
  logic [AW-1:0]          raddr;
  logic [VALUE_WIDTH-1:0] rval;
  logic [LW-1:0]          rnext, rprev;
  logic                   vwe, nwe, pwe;
  logic [AW-1:0]          vaddr, naddr, paddr;
  logic [VALUE_WIDTH-1:0] vdata;
  logic [LW-1:0]          ndata, pdata;

  cdl_pool #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH), .AW(AW), .LW(LW)) u_pool (
    .clk(clk), .raddr(raddr), .rval(rval), .rnext(rnext), .rprev(rprev),
    .vwe(vwe), .vaddr(vaddr), .vdata(vdata),
    .nwe(nwe), .naddr(naddr), .ndata(ndata),
    .pwe(pwe), .paddr(paddr), .pdata(pdata)
  );

  function automatic logic is_node(input logic [LW-1:0] x);
    return x < NIL;
  endfunction

  // A new request is taken in idle. The result register parts the two sides:
  // a waiting result only holds the next request in its final cycle, so a
  // waiting result never gets overwritten.
  assign req.ready      = (state == S_IDLE);
  assign load_out       = (state == S_OUT) && (!ovalid || rsp.ready);
  assign rsp.valid      = ovalid;
  assign rsp.status     = ostatus;
  assign rsp.read_value = DATA_W'(oval);
  assign rsp.count      = ocount;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= NIL;
      tail      <= NIL;
      cursor    <= NIL;
      free_head <= NIL;
      fresh     <= '0;
      count     <= '0;
      ovalid    <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      cursor    <= cursor_next;
      free_head <= free_head_next;
      fresh     <= fresh_next;
      count     <= count_next;
      if (load_out) ovalid <= 1'b1;
      else if (rsp.ready) ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      cmd <= cmd_t'(req.command);
      val <= VALUE_WIDTH'(req.value);
    end
    nn <= nn_next;
    lp <= lp_next;
    ls <= ls_next;
    st <= st_next;
    if (load_out) begin
      ostatus <= st;
      // The pool read issued in S_RV addressed the final cursor, and the
      // address has not moved since.
      oval    <= is_node(cursor) ? rval : '0;
      ocount  <= COUNT_W'(count);
    end
  end

  // Sequencer. RD1 reads the free-list head (insert) or the cursor node;
  // RD2 uses those links and, for insert, reads the cursor's links; WR and
  // WR2 write links back, and WR the new node's value, one entry per memory per
  // cycle; RV reads the value at the final cursor; OUT loads the result register.
  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    cursor_next    = cursor;
    free_head_next = free_head;
    fresh_next     = fresh;
    count_next     = count;
    nn_next        = nn;
    lp_next        = lp;
    ls_next        = ls;
    st_next        = st;
    raddr          = AW'(cursor);
    vwe = 1'b0; nwe = 1'b0; pwe = 1'b0;
    vaddr = AW'(cursor); naddr = AW'(cursor); paddr = AW'(cursor);
    vdata = val; ndata = NIL; pdata = NIL;
    case (state)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          state_next = S_RD1;
          st_next    = ST_OK;
        end
      end
      S_RD1: begin
        case (cmd)
          CMD_INSERT: begin
            // The free-list head's next link is needed to pop it.
            raddr = AW'(free_head);
            if (is_node(free_head)) begin
              nn_next = free_head;
              state_next = S_RD2;
            end else if (fresh < NIL) begin
              nn_next = fresh;
              state_next = S_RD2;
            end else begin
              st_next = ST_FULL;
              state_next = S_RV;
            end
          end
          CMD_CLEAR: begin
            head_next = NIL; tail_next = NIL; cursor_next = NIL;
            free_head_next = NIL; fresh_next = '0; count_next = '0;
            state_next = S_RV;
          end
          CMD_FIRST: begin
            cursor_next = head;
            st_next = is_node(head) ? ST_OK : ST_EMPTY;
            state_next = S_RV;
          end
          default: begin
            if (!is_node(cursor)) begin
              st_next = ST_EMPTY;
              state_next = S_RV;
            end else if (cmd == CMD_READ) begin
              state_next = S_RV;
            end else if (cmd == CMD_WRITE) begin
              vwe = 1'b1;
              state_next = S_RV;
            end else begin
              // Delete and steps read the cursor links at the default address.
              state_next = S_RD2;
            end
          end
        endcase
      end
      S_RD2: begin
        // rnext/rprev now hold the links of the node read in RD1.
        case (cmd)
          CMD_INSERT: begin
            if (is_node(free_head)) free_head_next = rnext;
            else fresh_next = fresh + LW'(1);
            raddr = AW'(cursor);
            state_next = S_WR;
          end
          CMD_DELETE: begin
            lp_next = rprev;
            ls_next = rnext;
            state_next = S_WR;
          end
          CMD_NEXT: begin
            if (is_node(rnext)) cursor_next = rnext;
            else begin cursor_next = tail; st_next = ST_END; end
            state_next = S_RV;
          end
          CMD_PREV: begin
            if (is_node(rprev)) cursor_next = rprev;
            else begin cursor_next = head; st_next = ST_END; end
            state_next = S_RV;
          end
          default: state_next = S_RV;
        endcase
      end
      S_WR: begin
        if (cmd == CMD_INSERT) begin
          // rnext is the cursor's successor when the cursor is a node.
          vwe = 1'b1; vaddr = AW'(nn); vdata = val;
          nwe = 1'b1; naddr = AW'(nn); ndata = is_node(cursor) ? rnext : NIL;
          pwe = 1'b1; paddr = AW'(nn); pdata = cursor;
          ls_next = rnext;
          if (is_node(cursor)) begin
            state_next = S_WR2;
          end else begin
            head_next = nn; tail_next = nn;
            cursor_next = nn;
            count_next = count + LW'(1);
            state_next = S_RV;
          end
        end else begin
          // Delete the cursor node with prev lp and next ls; it goes onto
          // the free list.
          nwe = 1'b1; naddr = AW'(cursor); ndata = free_head;
          free_head_next = cursor;
          if (is_node(ls)) begin pwe = 1'b1; paddr = AW'(ls); pdata = lp; end
          else tail_next = lp;
          if (is_node(lp)) begin
            cursor_next = lp;
            state_next = S_WR2;
          end else begin
            cursor_next = ls;
            head_next = ls;
            state_next = S_RV;
          end
          if (count != '0) count_next = count - LW'(1);
        end
      end
      S_WR2: begin
        if (cmd == CMD_INSERT) begin
          // Link the new node in after the cursor.
          nwe = 1'b1; naddr = AW'(cursor); ndata = nn;
          if (is_node(ls)) begin pwe = 1'b1; paddr = AW'(ls); pdata = nn; end
          else tail_next = nn;
          cursor_next = nn;
          count_next = count + LW'(1);
        end else begin
          // The predecessor's next link skips the deleted node.
          nwe = 1'b1; naddr = AW'(lp); ndata = ls;
        end
        state_next = S_RV;
      end
      S_RV: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        if (load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  `CDL_ASSERT_IMP(a_ready_idle, clk, rst, req.ready, state == S_IDLE, "ready outside idle")
  `CDL_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= NIL, "count overflow")
  `CDL_ASSERT_NEXT(a_out_valid, clk, rst, state == S_OUT, ovalid, "result not registered")
  `CDL_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.read_value), "result dropped while stalled")
endmodule
